// ----- hw/rtl/pht_pkg.sv -----
// shared types and constants of the ppp hdlc frame transmitter
// no dependencies
package pht_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  ESC_XOR     = 8'h20;
    localparam logic [7:0]  ADDR_BYTE   = 8'hFF;
    localparam logic [7:0]  CTRL_BYTE   = 8'h03;
    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [31:0] MAP_DEFAULT = 32'h000E_0000;
    localparam logic [15:0] PROTO_RESET = 16'h0000;
    localparam int          FIFO_DEPTH  = 4;

    typedef enum logic [0:0] {
        REG_PROTOCOL = 1'b0,
        REG_ESC_MAP  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       fin;
        logic       present;
        logic       esc;
    } t_item;

    typedef enum logic [3:0] {
        S_FLAG_OPEN,
        S_ADDR,
        S_CTRL,
        S_PROTO_LO,
        S_PROTO_HI,
        S_DATA,
        S_ESC_DATA,
        S_FCS_LO,
        S_FCS_HI,
        S_FLAG_CLOSE
    } t_step;

endpackage

// ----- hw/rtl/pht_front.sv -----
// front end: accepts request items, decides escaping, drops empty items
// depends on pht_pkg
module pht_front (
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_frame_start,
    input  logic          i_frame_end,
    input  logic          i_byte_present,
    input  logic [31:0]   i_escape_map,
    output logic          o_push,
    output pht_pkg::t_item o_item,
    input  logic          i_full
);
    import pht_pkg::*;

    logic w_ctrl;
    logic w_keep;

    always_comb begin
        w_ctrl = (i_data_byte[7:5] == 3'b000) && i_escape_map[i_data_byte[4:0]];
        o_item.data    = i_data_byte;
        o_item.start   = i_frame_start;
        o_item.fin     = i_frame_end;
        o_item.present = i_byte_present;
        o_item.esc     = (i_data_byte == ESC_BYTE) || (i_data_byte == FLAG_BYTE) || w_ctrl;
        w_keep         = i_frame_start | i_frame_end | i_byte_present;
        o_in_ready     = !i_full;
        o_push         = i_in_valid && !i_full && w_keep;
    end

endmodule

// ----- hw/rtl/pht_fifo.sv -----
// short item queue between front and back end
// depends on pht_pkg
module pht_fifo #(
    parameter int DEPTH = pht_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pht_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output pht_pkg::t_item o_head,
    output logic           o_empty
);
    import pht_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);

endmodule

// ----- hw/rtl/pht_back.sv -----
// back end: walks each item through header, payload and trailer bytes,
// keeps the running fcs-16 and drives the output register; depends on pht_pkg
module pht_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pht_pkg::t_item i_head,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic [15:0]    i_protocol_word,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last
);
    import pht_pkg::*;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    t_step       r_step, n_step;
    logic        r_busy, n_busy;
    logic [15:0] r_crc, n_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    t_step       w_cur;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_fire;
    t_step       w_after_hdr;
    t_step       w_after_data;

    always_comb begin
        w_fire       = !i_empty && (!r_out_valid || i_out_ready);
        w_after_data = S_FCS_LO;
        w_after_hdr  = i_head.present ? S_DATA : S_FCS_LO;
        if (r_busy) begin
            w_cur = r_step;
        end else if (i_head.start) begin
            w_cur = S_FLAG_OPEN;
        end else if (i_head.present) begin
            w_cur = S_DATA;
        end else begin
            w_cur = S_FCS_LO;
        end

        w_byte = FLAG_BYTE;
        w_last = 1'b0;
        n_crc  = r_crc;
        n_step = w_cur;
        case (w_cur)
            S_FLAG_OPEN: begin
                w_byte = FLAG_BYTE;
                n_crc  = CRC_SEED;
                n_step = S_ADDR;
            end
            S_ADDR: begin
                w_byte = ADDR_BYTE;
                n_crc  = crc_byte(r_crc, ADDR_BYTE);
                n_step = S_CTRL;
            end
            S_CTRL: begin
                w_byte = CTRL_BYTE;
                n_crc  = crc_byte(r_crc, CTRL_BYTE);
                n_step = S_PROTO_LO;
            end
            S_PROTO_LO: begin
                w_byte = i_protocol_word[7:0];
                n_crc  = crc_byte(r_crc, i_protocol_word[7:0]);
                n_step = S_PROTO_HI;
            end
            S_PROTO_HI: begin
                w_byte = i_protocol_word[15:8];
                n_crc  = crc_byte(r_crc, i_protocol_word[15:8]);
                n_step = w_after_hdr;
                w_last = !i_head.present && !i_head.fin;
            end
            S_DATA: begin
                w_byte = i_head.esc ? ESC_BYTE : i_head.data;
                n_crc  = crc_byte(r_crc, i_head.data);
                n_step = i_head.esc ? S_ESC_DATA : w_after_data;
                w_last = !i_head.esc && !i_head.fin;
            end
            S_ESC_DATA: begin
                w_byte = i_head.data ^ ESC_XOR;
                n_step = w_after_data;
                w_last = !i_head.fin;
            end
            S_FCS_LO: begin
                w_byte = ~r_crc[7:0];
                n_step = S_FCS_HI;
            end
            S_FCS_HI: begin
                w_byte = ~r_crc[15:8];
                n_step = S_FLAG_CLOSE;
            end
            S_FLAG_CLOSE: begin
                w_byte = FLAG_BYTE;
                n_crc  = CRC_SEED;
                w_last = 1'b1;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase

        n_busy = r_busy;
        if (w_fire) begin
            n_busy = !w_last;
        end
        o_pop = w_fire && w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_FLAG_OPEN;
            r_busy      <= 1'b0;
            r_crc       <= CRC_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_fire) begin
                r_step      <= n_step;
                r_crc       <= n_crc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

endmodule

// ----- hw/rtl/ppp_hdlc_frame_transmitter_unit.sv -----
// the first line byte of an item passes through the item queue and then the output register
// throughput: one line byte per cycle from the back end while the output is not
// stalled; each item causes 1 to 10 line bytes; the item queue takes a new
// item every cycle until it fills
// reset: synchronous, active low; clears the queue and the fcs, loads register defaults
module ppp_hdlc_frame_transmitter_unit #(
    parameter int FIFO_DEPTH = pht_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    input  logic        i_byte_present,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last
);
    import pht_pkg::*;

    logic [15:0] r_protocol_word;
    logic [31:0] r_escape_map;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_item w_in_item;
    t_item w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol_word <= PROTO_RESET;
            r_escape_map    <= MAP_DEFAULT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PROTOCOL: r_protocol_word <= i_cfg_wdata[15:0];
                REG_ESC_MAP:  r_escape_map    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pht_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_frame_start  (i_frame_start),
        .i_frame_end    (i_frame_end),
        .i_byte_present (i_byte_present),
        .i_escape_map   (r_escape_map),
        .o_push         (w_push),
        .o_item         (w_in_item),
        .i_full         (w_full)
    );

    pht_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    pht_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .i_protocol_word (r_protocol_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last)
    );

endmodule

// ----- hw/rtl/pht_checker.sv -----
// port-level checks of the ppp hdlc frame transmitter, bound to its top level
// depends on ppp_hdlc_frame_transmitter_unit ports only
module pht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_run_last
);

    a_reset_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_in_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("stalled output changed");

    // a request's bytes leave without gaps
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_run_last |=> o_out_valid)
        else $error("gap inside a byte run");

endmodule

bind ppp_hdlc_frame_transmitter_unit pht_checker u_pht_checker (.*);
